>>> rtl/msgrf_pkg.sv
// Shared constants, codes and controller command type for the message ring FIFO.
package msgrf_pkg;

    localparam int SLOTS_DEF       = 8;
    localparam int SLOT_BYTES_DEF  = 512;
    localparam int MAX_OPENERS_DEF = 255;

    localparam logic [1:0] ACT_WRITE   = 2'd0;
    localparam logic [1:0] ACT_READ    = 2'd1;
    localparam logic [1:0] ACT_OPEN    = 2'd2;
    localparam logic [1:0] ACT_RELEASE = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BLOCK    = 3'd1;
    localparam logic [2:0] ST_EOF      = 3'd2;
    localparam logic [2:0] ST_NOREADER = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;

    typedef struct packed {
        logic capture;
        logic execute;
        logic publish;
    } t_cmd;

endpackage

>>> rtl/msgrf_ctrl.sv
// Sequencer for the message ring FIFO: capture, execute, publish.
module msgrf_ctrl
    import msgrf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    output logic o_valid,
    input  logic i_stall,
    output t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    t_cmd       cmd;

    always_comb begin
        n_state     = r_state;
        cmd         = '0;
        n_out_valid = r_out_valid && i_stall;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    cmd.capture = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.execute = 1'b1;
                n_state     = S_LOAD;
            end
            S_LOAD: begin
                // hold the result until the output register is free
                if (!r_out_valid || !i_stall) begin
                    cmd.publish = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_cmd   = cmd;

endmodule

>>> rtl/msgrf_datapath.sv
// Slot memories, ring pointers, opener counts and result register.
module msgrf_datapath
    import msgrf_pkg::*;
#(
    parameter int SLOTS       = SLOTS_DEF,
    parameter int SLOT_BYTES  = SLOT_BYTES_DEF,
    parameter int MAX_OPENERS = MAX_OPENERS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  logic [1:0] i_action,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    input  logic       i_open_for_read,
    input  logic       i_open_for_write,
    output logic [2:0] o_status,
    output logic [7:0] o_read_data,
    output logic       o_read_last,
    output logic       o_readable,
    output logic       o_writable
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int OFF_W  = $clog2(SLOT_BYTES + 1);
    localparam int ADDR_W = $clog2(SLOTS * SLOT_BYTES);
    localparam int CNT_W  = $clog2(MAX_OPENERS + 1);
    localparam int DEPTH  = SLOTS * SLOT_BYTES;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);
    localparam logic [OFF_W-1:0]  FULL_OFF  = OFF_W'(SLOT_BYTES);
    localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_OPENERS);

    logic [7:0]       byte_mem [DEPTH];
    logic [OFF_W-1:0] len_mem  [SLOTS];

    logic [1:0]        r_act;
    logic [7:0]        r_byte;
    logic              r_last, r_for_rd, r_for_wr;
    logic [SLOT_W-1:0] r_head, r_tail, n_head, n_tail;
    logic [OFF_W-1:0]  r_woff, r_roff, n_woff, n_roff;
    logic [CNT_W-1:0]  r_readers, r_writers, n_readers, n_writers;
    logic [OFF_W-1:0]  r_head_len;
    logic [7:0]        r_mem_q;
    logic [2:0]        r_p_status, n_p_status;
    logic              r_p_rd, n_p_rd, r_p_last, n_p_last;
    logic [2:0]        r_status;
    logic [7:0]        r_read_data;
    logic              r_read_last, r_readable, r_writable;

    logic              wr_en, rd_en, len_wr_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [OFF_W-1:0]  len_eff, roff_eff, roff_inc, woff_inc;
    logic [SLOT_W-1:0] tail_nx, head_nx;
    logic              full, empty;

    always_comb begin
        tail_nx  = (r_tail == LAST_SLOT) ? '0 : r_tail + SLOT_W'(1);
        head_nx  = (r_head == LAST_SLOT) ? '0 : r_head + SLOT_W'(1);
        full     = (tail_nx == r_head);
        empty    = (r_head == r_tail);
        // length of a committed message is always 1..SLOT_BYTES; clamp anyway
        len_eff  = (r_head_len > FULL_OFF) ? FULL_OFF :
                   ((r_head_len == '0) ? OFF_W'(1) : r_head_len);
        roff_eff = (r_roff >= len_eff) ? len_eff - OFF_W'(1) : r_roff;
        roff_inc = roff_eff + OFF_W'(1);
        woff_inc = r_woff + OFF_W'(1);
        wr_addr  = ADDR_W'(r_tail) * ADDR_W'(SLOT_BYTES) + ADDR_W'(r_woff);
        rd_addr  = ADDR_W'(r_head) * ADDR_W'(SLOT_BYTES) + ADDR_W'(roff_eff);

        n_head     = r_head;
        n_tail     = r_tail;
        n_woff     = r_woff;
        n_roff     = r_roff;
        n_readers  = r_readers;
        n_writers  = r_writers;
        n_p_status = ST_OK;
        n_p_rd     = 1'b0;
        n_p_last   = 1'b0;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        len_wr_en  = 1'b0;

        unique case (r_act)
            ACT_WRITE: begin
                if (r_woff == '0 && full) begin
                    n_p_status = (r_readers == '0) ? ST_NOREADER : ST_BLOCK;
                end else begin
                    if (r_woff < FULL_OFF) begin
                        wr_en  = 1'b1;
                        n_woff = woff_inc;
                    end else begin
                        n_p_status = ST_OVERFLOW;
                    end
                    // commit: store length, advance tail
                    if (r_last) begin
                        len_wr_en = 1'b1;
                        n_tail    = tail_nx;
                        n_woff    = '0;
                    end
                end
            end
            ACT_READ: begin
                if (empty) begin
                    n_p_status = (r_writers == '0) ? ST_EOF : ST_BLOCK;
                end else begin
                    rd_en  = 1'b1;
                    n_p_rd = 1'b1;
                    n_roff = roff_inc;
                    if (roff_inc >= len_eff) begin
                        n_p_last = 1'b1;
                        n_head   = head_nx;
                        n_roff   = '0;
                    end
                end
            end
            ACT_OPEN: begin
                if (r_for_rd && r_readers < CNT_MAX) n_readers = r_readers + CNT_W'(1);
                if (r_for_wr && r_writers < CNT_MAX) n_writers = r_writers + CNT_W'(1);
            end
            ACT_RELEASE: begin
                if (r_for_rd && r_readers != '0) n_readers = r_readers - CNT_W'(1);
                if (r_for_wr && r_writers != '0) n_writers = r_writers - CNT_W'(1);
            end
            default: begin
                n_p_status = ST_OK;
            end
        endcase
    end

    // memories: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute && wr_en) byte_mem[wr_addr] <= r_byte;
        if (i_cmd.execute && rd_en) r_mem_q <= byte_mem[rd_addr];
    end

    // length of the head slot is fetched every cycle; the publish and idle states
    // lie between the last update of head or a length and the next execute
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute && len_wr_en) len_mem[r_tail] <= n_woff == '0 ?
            ((r_woff < FULL_OFF) ? woff_inc : r_woff) : n_woff;
        r_head_len <= len_mem[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_act    <= i_action;
            r_byte   <= i_data_byte;
            r_last   <= i_last_byte;
            r_for_rd <= i_open_for_read;
            r_for_wr <= i_open_for_write;
        end
        if (i_cmd.execute) begin
            r_p_status <= n_p_status;
            r_p_rd     <= n_p_rd;
            r_p_last   <= n_p_last;
        end
        if (i_cmd.publish) begin
            r_status    <= r_p_status;
            r_read_data <= r_p_rd ? r_mem_q : 8'd0;
            r_read_last <= r_p_last;
            r_readable  <= (r_head != r_tail);
            r_writable  <= !full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_tail    <= '0;
            r_woff    <= '0;
            r_roff    <= '0;
            r_readers <= '0;
            r_writers <= '0;
        end else if (i_cmd.execute) begin
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_woff    <= n_woff;
            r_roff    <= n_roff;
            r_readers <= n_readers;
            r_writers <= n_writers;
        end
    end

    assign o_status    = r_status;
    assign o_read_data = r_read_data;
    assign o_read_last = r_read_last;
    assign o_readable  = r_readable;
    assign o_writable  = r_writable;

endmodule

>>> rtl/message_ring_fifo_top.sv
// Top level of the message ring FIFO: sequencer plus datapath.
//
// Input channel (i_valid / o_stall) carries one word per operation: write a
// byte, read a byte, open or release. Every accepted word gives exactly one
// result word on the output channel (o_valid / i_stall) with a status, the
// read byte and its last flag, and the readable / writable poll flags.
// An operation passes through capture, execute with the memory access and
// publish, and the block accepts a new word only once the previous one has
// published its result; the input capture, the registered read of the byte
// memory and the result register set these steps.
// While the receiver stalls, the held result stays stable and the next
// operation may still be accepted and executed; its result waits in the
// datapath until the output register is taken, and input stalls meanwhile.
// Reset (synchronous, active low) empties the ring, clears both offsets and
// both opener counts. Slot contents are not cleared; only committed data is
// ever read back.
module message_ring_fifo_top
    import msgrf_pkg::*;
#(
    parameter int SLOTS       = SLOTS_DEF,
    parameter int SLOT_BYTES  = SLOT_BYTES_DEF,
    parameter int MAX_OPENERS = MAX_OPENERS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_action,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    input  logic       i_open_for_read,
    input  logic       i_open_for_write,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_status,
    output logic [7:0] o_read_data,
    output logic       o_read_last,
    output logic       o_readable,
    output logic       o_writable
);

    t_cmd cmd;

    msgrf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd)
    );

    msgrf_datapath #(
        .SLOTS       (SLOTS),
        .SLOT_BYTES  (SLOT_BYTES),
        .MAX_OPENERS (MAX_OPENERS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_action         (i_action),
        .i_data_byte      (i_data_byte),
        .i_last_byte      (i_last_byte),
        .i_open_for_read  (i_open_for_read),
        .i_open_for_write (i_open_for_write),
        .o_status         (o_status),
        .o_read_data      (o_read_data),
        .o_read_last      (o_read_last),
        .o_readable       (o_readable),
        .o_writable       (o_writable)
    );

endmodule

>>> bench/msgrf_checker.sv
// Checker for the message ring FIFO: predicts every result word and compares it.
`timescale 1ns / 100ps

module msgrf_checker
    import msgrf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [1:0] i_action,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    input  logic       i_open_for_read,
    input  logic       i_open_for_write,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [2:0] i_status,
    input  logic [7:0] i_read_data,
    input  logic       i_read_last,
    input  logic       i_readable,
    input  logic       i_writable,
    output int         o_errors,
    output int         o_outstanding
);

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] data;
        logic       last;
        logic       readable;
        logic       writable;
    } t_response;

    t_response  due_responses[$];

    logic [7:0] slot_bytes [SLOTS_DEF * SLOT_BYTES_DEF];
    int         slot_len [SLOTS_DEF];
    int         head;
    int         tail;
    int         wr_off;
    int         rd_off;
    int         readers;
    int         writers;

    function automatic int bump(input int slot);
        return (slot + 1 == SLOTS_DEF) ? 0 : slot + 1;
    endfunction

    // Apply one word to the ring image and return the response it earns.
    function automatic t_response ring_response(input logic [1:0] act, input logic [7:0] dat,
                                                 input logic lst, input logic rd,
                                                 input logic wr);
        t_response r;
        r = '0;
        r.status = ST_OK;
        case (act)
            ACT_WRITE: begin
                // Fullness counts only at the first byte of a message.
                if (wr_off == 0 && bump(tail) == head) begin
                    r.status = (readers == 0) ? ST_NOREADER : ST_BLOCK;
                end else begin
                    if (wr_off < SLOT_BYTES_DEF) begin
                        slot_bytes[tail * SLOT_BYTES_DEF + wr_off] = dat;
                        wr_off++;
                    end else begin
                        r.status = ST_OVERFLOW;
                    end
                    if (lst) begin
                        slot_len[tail] = wr_off;
                        tail = bump(tail);
                        wr_off = 0;
                    end
                end
            end
            ACT_READ: begin
                if (head == tail) begin
                    r.status = (writers == 0) ? ST_EOF : ST_BLOCK;
                end else begin
                    r.data = slot_bytes[head * SLOT_BYTES_DEF + rd_off];
                    rd_off++;
                    if (rd_off >= slot_len[head]) begin
                        r.last = 1'b1;
                        head = bump(head);
                        rd_off = 0;
                    end
                end
            end
            ACT_OPEN: begin
                if (rd && readers < MAX_OPENERS_DEF) readers++;
                if (wr && writers < MAX_OPENERS_DEF) writers++;
            end
            default: begin
                if (rd && readers > 0) readers--;
                if (wr && writers > 0) writers--;
            end
        endcase
        r.readable = (head != tail);
        r.writable = (bump(tail) != head);
        return r;
    endfunction

    task automatic report(input string field, input int want, input int got);
        $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, field, want, got);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_response want;
        if (!i_rst_n) begin
            head = 0;
            tail = 0;
            wr_off = 0;
            rd_off = 0;
            readers = 0;
            writers = 0;
            due_responses.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (due_responses.size() == 0) begin
                    report("unexpected result word", 0, 1);
                end else begin
                    want = due_responses.pop_front();
                    if (i_status !== want.status)
                        report("status", int'(want.status), int'(i_status));
                    if (i_read_data !== want.data)
                        report("read_data", int'(want.data), int'(i_read_data));
                    if (i_read_last !== want.last)
                        report("read_last", int'(want.last), int'(i_read_last));
                    if (i_readable !== want.readable)
                        report("readable", int'(want.readable), int'(i_readable));
                    if (i_writable !== want.writable)
                        report("writable", int'(want.writable), int'(i_writable));
                end
            end
            if (i_in_valid && !i_in_stall)
                due_responses.push_back(ring_response(i_action, i_data_byte, i_last_byte,
                                                      i_open_for_read, i_open_for_write));
        end
        o_outstanding = due_responses.size();
    end

endmodule

>>> bench/tb.sv
// Testbench top for the message ring FIFO: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb
    import msgrf_pkg::*;
();

    localparam int ITEMS       = 1600;
    localparam int CYCLE_LIMIT = 800000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [1:0] i_action = ACT_OPEN;
    logic [7:0] i_data_byte = '0;
    logic       i_last_byte = 1'b0;
    logic       i_open_for_read = 1'b0;
    logic       i_open_for_write = 1'b0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [2:0] o_status;
    logic [7:0] o_read_data;
    logic       o_read_last;
    logic       o_readable;
    logic       o_writable;

    int         errors;
    int         outstanding;
    int         cycles = 0;
    int         sent = 0;
    bit         quiet = 1'b0;
    bit         idle_on = 1'b1;

    message_ring_fifo_top u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_action         (i_action),
        .i_data_byte      (i_data_byte),
        .i_last_byte      (i_last_byte),
        .i_open_for_read  (i_open_for_read),
        .i_open_for_write (i_open_for_write),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_status         (o_status),
        .o_read_data      (o_read_data),
        .o_read_last      (o_read_last),
        .o_readable       (o_readable),
        .o_writable       (o_writable)
    );

    msgrf_checker u_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_stall       (o_stall),
        .i_action         (i_action),
        .i_data_byte      (i_data_byte),
        .i_last_byte      (i_last_byte),
        .i_open_for_read  (i_open_for_read),
        .i_open_for_write (i_open_for_write),
        .i_out_valid      (o_valid),
        .i_out_stall      (i_stall),
        .i_status         (o_status),
        .i_read_data      (o_read_data),
        .i_read_last      (o_read_last),
        .i_readable       (o_readable),
        .i_writable       (o_writable),
        .o_errors         (errors),
        .o_outstanding    (outstanding)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver side: free-running stretches broken by stall bursts.
    initial begin
        int run;
        int hold;
        forever begin
            run = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 15);
            repeat (run) @(posedge i_clk);
            if (!quiet) begin
                hold = $urandom_range(1, 13);
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // Present one word, optionally after an idle burst, and hold it until taken.
    task automatic send_word(input logic [1:0] act, input logic [7:0] dat, input logic lst,
                             input logic rd, input logic wr);
        if (!quiet && idle_on && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_action         <= act;
        i_data_byte      <= dat;
        i_last_byte      <= lst;
        i_open_for_read  <= rd;
        i_open_for_write <= wr;
        do @(posedge i_clk); while (o_stall);
        sent++;
    endtask

    initial begin
        int len;
        int pick;
        int wr_share;
        int est_bytes;
        int longs;
        int burst_phase;
        bit filling;
        bit swept;
        est_bytes = 0;
        longs = 0;
        burst_phase = 0;
        filling = 1'b1;
        swept = 1'b0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty ring with no writers, then count floors and a writer.
        send_word(ACT_READ, 8'h5A, 1'b0, 1'b0, 1'b0);
        send_word(ACT_RELEASE, 8'h00, 1'b0, 1'b1, 1'b1);
        send_word(ACT_OPEN, 8'h00, 1'b0, 1'b0, 1'b1);
        send_word(ACT_READ, 8'hA5, 1'b1, 1'b1, 1'b1);
        send_word(ACT_OPEN, 8'hFF, 1'b1, 1'b0, 1'b0);
        // Two-byte message at the byte extremes, read back.
        send_word(ACT_WRITE, 8'h00, 1'b0, 1'b0, 1'b0);
        send_word(ACT_WRITE, 8'hFF, 1'b1, 1'b1, 1'b1);
        send_word(ACT_READ, 8'h00, 1'b0, 1'b0, 1'b0);
        send_word(ACT_READ, 8'h00, 1'b0, 1'b0, 1'b0);
        // A partly written message must not be readable.
        send_word(ACT_WRITE, 8'h11, 1'b0, 1'b0, 1'b0);
        send_word(ACT_READ, 8'h00, 1'b0, 1'b0, 1'b0);
        send_word(ACT_WRITE, 8'h22, 1'b1, 1'b0, 1'b0);
        // Fill the ring, refuse with no reader, then with a reader.
        for (int k = 0; k < SLOTS_DEF - 2; k++)
            send_word(ACT_WRITE, 8'(8'h30 + k), 1'b1, 1'b0, 1'b0);
        send_word(ACT_WRITE, 8'hC3, 1'b1, 1'b0, 1'b0);
        send_word(ACT_OPEN, 8'h00, 1'b0, 1'b1, 1'b0);
        send_word(ACT_WRITE, 8'h3C, 1'b1, 1'b0, 1'b0);
        send_word(ACT_READ, 8'h00, 1'b0, 1'b0, 1'b0);
        send_word(ACT_WRITE, 8'h81, 1'b1, 1'b0, 1'b0);
        est_bytes = SLOTS_DEF;

        while (sent < ITEMS) begin
            if (sent >= ITEMS - 200) quiet = 1'b1;
            if (sent / 120 != burst_phase) begin
                burst_phase = sent / 120;
                idle_on = ($urandom_range(0, 3) != 0);
                filling = !filling;
            end
            pick = $urandom_range(0, 99);
            wr_share = filling ? 60 : 30;
            if (pick < 5) begin
                send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
            end else if (pick < 5 + wr_share) begin
                // Mostly short messages; a few run past the slot size.
                if (longs < 3 && ($urandom_range(0, 39) == 0 || (sent > 900 && longs == 0))) begin
                    len = $urandom_range(SLOT_BYTES_DEF - 2, SLOT_BYTES_DEF + 4);
                    longs++;
                end else begin
                    len = $urandom_range(1, 8);
                end
                for (int k = 1; k <= len; k++)
                    send_word(ACT_WRITE, 8'($urandom_range(0, 255)), k == len,
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                est_bytes += (len > SLOT_BYTES_DEF) ? SLOT_BYTES_DEF : len;
            end else if (pick < 90) begin
                len = ($urandom_range(0, 3) == 0 && est_bytes > 0) ? est_bytes
                                                                  : $urandom_range(1, 10);
                for (int k = 0; k < len; k++)
                    send_word(ACT_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                est_bytes = (est_bytes > len) ? est_bytes - len : 0;
            end else if (!swept && ($urandom_range(0, 9) == 0 || sent > 1000)) begin
                // Drive both counts past the ceiling, then back past the floor.
                repeat (MAX_OPENERS_DEF + 3)
                    send_word(ACT_OPEN, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                              1'b1, 1'b1);
                repeat (MAX_OPENERS_DEF + 3)
                    send_word(ACT_RELEASE, 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)), 1'b1, 1'b1);
                swept = 1'b1;
            end else begin
                send_word(($urandom_range(0, 2) != 0) ? ACT_OPEN : ACT_RELEASE,
                          8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
        end
        i_valid <= 1'b0;

        do @(negedge i_clk); while (outstanding != 0);
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
